// ----- hw/rtl/mpr_pkg.sv -----
`timescale 1ns / 1ps

package mpr_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int ADDR_W     = 48;
    localparam int TOTAL_W    = 5;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              fire;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/mpr_cell.sv -----
`timescale 1ns / 1ps

module mpr_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mpr_pkg::cell_cmd_t              cmd,
    input  logic                            claim_in,
    output logic                            claim_out,
    output logic                            match
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [mpr_pkg::ADDR_W-1:0] addr_reg;
    logic                       load;

    assign match     = valid_reg && (addr_reg == cmd.addr);
    // a free slot stops the claim; only the lowest free cell sees it
    assign claim_out = claim_in & valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        load       = 1'b0;
        if (cmd.fire)
        begin
            unique case (cmd.op)
                mpr_pkg::OP_ADD:
                begin
                    if (!cmd.hit && claim_in && !valid_reg)
                    begin
                        valid_next = 1'b1;
                        load       = 1'b1;
                    end
                end
                mpr_pkg::OP_QUERY:
                begin
                    valid_next = valid_reg;
                end
                mpr_pkg::OP_REMOVE:
                begin
                    if (match)
                    begin
                        valid_next = 1'b0;
                    end
                end
                mpr_pkg::OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= cmd.addr;
        end
    end

endmodule

// ----- hw/rtl/mac_peer_registry.sv -----
`timescale 1ns / 1ps
// channel   | direction | ports                              | handshake
// ----------+-----------+------------------------------------+------------------------
// request   | in        | operation, station_address         | start & !busy
// result    | out       | success, entry_total               | done, one cycle
//
// For each item the accept edge loads the request, the next edge updates
// the cell row and raises done; start is taken again in the done cycle.
// The row of slot cells compares all addresses at once; the lowest free slot is
// found by a claim passed from cell to cell.
// Reset clears every valid bit and the entry count at once; no clearing pass.
// The receiver cannot stall: done lasts exactly one cycle.

module mac_peer_registry (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [mpr_pkg::ADDR_W-1:0]      station_address,
    output logic                            done,
    output logic                            success,
    output logic [mpr_pkg::TOTAL_W-1:0]     entry_total
);

    logic                           pend_reg;
    logic                           pend_next;
    mpr_pkg::op_t                   op_reg;
    logic [mpr_pkg::ADDR_W-1:0]     addr_reg;
    logic                           done_reg;
    logic                           done_next;
    logic                           success_reg;
    logic                           success_next;
    logic [mpr_pkg::CNT_W-1:0]      count_reg;
    logic [mpr_pkg::CNT_W-1:0]      count_next;

    logic                           accept;
    logic                           hit;
    logic                           full;
    logic [mpr_pkg::SLOT_COUNT:0]   claim;
    logic [mpr_pkg::SLOT_COUNT-1:0] match_vec;
    mpr_pkg::cell_cmd_t             cmd;

    assign accept      = start && !pend_reg;
    assign busy        = pend_reg;
    assign done        = done_reg;
    assign success     = success_reg;
    assign entry_total = mpr_pkg::TOTAL_W'(count_reg);

    assign cmd.op   = op_reg;
    assign cmd.addr = addr_reg;
    assign cmd.hit  = hit;
    assign cmd.fire = pend_reg;

    assign claim[0] = 1'b1;
    assign hit      = |match_vec;
    assign full     = claim[mpr_pkg::SLOT_COUNT];

    genvar g;
    generate
        for (g = 0; g < mpr_pkg::SLOT_COUNT; g++)
        begin : g_cell
            mpr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .claim_in  (claim[g]),
                .claim_out (claim[g+1]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        pend_next    = accept;
        done_next    = pend_reg;
        success_next = success_reg;
        count_next   = count_reg;
        if (pend_reg)
        begin
            unique case (op_reg)
                mpr_pkg::OP_ADD:
                begin
                    success_next = hit || !full;
                    if (!hit && !full)
                    begin
                        count_next = count_reg + mpr_pkg::CNT_W'(1);
                    end
                end
                mpr_pkg::OP_QUERY:
                begin
                    success_next = hit;
                end
                mpr_pkg::OP_REMOVE:
                begin
                    success_next = hit;
                    if (hit)
                    begin
                        count_next = count_reg - mpr_pkg::CNT_W'(1);
                    end
                end
                mpr_pkg::OP_CLEAR:
                begin
                    success_next = 1'b1;
                    count_next   = '0;
                end
                default:
                begin
                    success_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg <= success_next;
        if (accept)
        begin
            op_reg   <= mpr_pkg::op_t'(operation);
            addr_reg <= station_address;
        end
    end

endmodule

// ----- hw/rtl/mpr_checker.sv -----
`timescale 1ns / 1ps

module mpr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [mpr_pkg::ADDR_W-1:0]      station_address,
    input  logic                            done,
    input  logic                            success,
    input  logic [mpr_pkg::TOTAL_W-1:0]     entry_total
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result not given one cycle after busy");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a pending item");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == mpr_pkg::OP_CLEAR)
        |=> ##1 (done && success && (entry_total == '0)))
        else $error("clear did not report an empty table");

endmodule

bind mac_peer_registry mpr_checker u_mpr_checker (.*);
